@@ src/hse_pkg.sv @@
// ----------------------------------------------------------------------------
// hse_pkg
// Shared constants, control word types and the microprogram of the heap
// sort engine.
// ----------------------------------------------------------------------------
package hse_pkg;

  localparam int MAX_ITEMS   = 64;
  localparam int STORE_DEPTH = 64;
  localparam int DATA_W      = 32;
  localparam int ADDR_W      = $clog2(STORE_DEPTH);
  localparam int CNT_W       = $clog2(MAX_ITEMS + 1);
  localparam int CHILD_W     = ADDR_W + 1;
  localparam int CMP_W       = 12;
  localparam int PC_W        = 5;

  localparam logic [CMP_W-1:0] CMP_MAX = '1;

  typedef logic [PC_W-1:0] pc_t;

  // datapath micro-operations
  typedef enum logic [4:0] {
    OP_NONE       = 5'd0,
    OP_LOAD       = 5'd1,
    OP_SETUP      = 5'd2,
    OP_BDEC       = 5'd3,
    OP_EXINIT     = 5'd4,
    OP_SWAP_RD    = 5'd5,
    OP_SWAP_WR1   = 5'd6,
    OP_SWAP_WR2   = 5'd7,
    OP_SIFT_ROOT  = 5'd8,
    OP_SIFT_HELD  = 5'd9,
    OP_SIFT_KIDS  = 5'd10,
    OP_SIFT_PICK  = 5'd11,
    OP_SIFT_MOVE  = 5'd12,
    OP_SIFT_END   = 5'd13,
    OP_EMIT_INIT  = 5'd14,
    OP_EMIT_RD    = 5'd15,
    OP_EMIT       = 5'd16,
    OP_CLEAR      = 5'd17
  } dp_op_t;

  // jump conditions
  typedef enum logic [2:0] {
    C_ALWAYS    = 3'd0,
    C_WAIT_LOAD = 3'd1,
    C_I_ZERO    = 3'd2,
    C_CHILD_OUT = 3'd3,
    C_HELD_LT   = 3'd4,
    C_OUT_STALL = 3'd5,
    C_K_LT_N    = 3'd6
  } cond_t;

  typedef enum logic [1:0] {
    SQ_NEXT = 2'd0,
    SQ_JUMP = 2'd1,
    SQ_CALL = 2'd2,
    SQ_RET  = 2'd3
  } seq_op_t;

  typedef struct packed {
    seq_op_t seq;
    cond_t   cond;
    pc_t     target;
    dp_op_t  op;
  } ctrl_t;

  typedef struct packed {
    logic load_done;
    logic i_zero;
    logic child_out;
    logic held_lt;
    logic out_stall;
    logic k_lt_n;
  } status_t;

  // program addresses
  localparam pc_t P_LOAD   = pc_t'(0);
  localparam pc_t P_SETUP  = pc_t'(1);
  localparam pc_t P_BTEST  = pc_t'(2);
  localparam pc_t P_BDEC   = pc_t'(3);
  localparam pc_t P_BLOOP  = pc_t'(4);
  localparam pc_t P_EXINIT = pc_t'(5);
  localparam pc_t P_ETEST  = pc_t'(6);
  localparam pc_t P_SWRD   = pc_t'(7);
  localparam pc_t P_SWW1   = pc_t'(8);
  localparam pc_t P_SWW2   = pc_t'(9);
  localparam pc_t P_ELOOP  = pc_t'(10);
  localparam pc_t P_SIFT   = pc_t'(11);
  localparam pc_t P_SHELD  = pc_t'(12);
  localparam pc_t P_SLOOP  = pc_t'(13);
  localparam pc_t P_SPICK  = pc_t'(14);
  localparam pc_t P_SMOVE  = pc_t'(15);
  localparam pc_t P_SEND   = pc_t'(16);
  localparam pc_t P_EMINIT = pc_t'(17);
  localparam pc_t P_EREAD  = pc_t'(18);
  localparam pc_t P_EMIT   = pc_t'(19);
  localparam pc_t P_ENEXT  = pc_t'(20);
  localparam pc_t P_CLEAR  = pc_t'(21);

  function automatic ctrl_t uw(input seq_op_t s, input cond_t c, input pc_t t,
                               input dp_op_t o);
    ctrl_t w;
    w.seq    = s;
    w.cond   = c;
    w.target = t;
    w.op     = o;
    return w;
  endfunction

  // microprogram ROM
  function automatic ctrl_t ucode(input pc_t pc);
    ctrl_t w;
    unique case (pc)
      P_LOAD:   w = uw(SQ_JUMP, C_WAIT_LOAD, P_LOAD,   OP_LOAD);
      P_SETUP:  w = uw(SQ_NEXT, C_ALWAYS,    P_LOAD,   OP_SETUP);
      P_BTEST:  w = uw(SQ_JUMP, C_I_ZERO,    P_EXINIT, OP_NONE);
      P_BDEC:   w = uw(SQ_CALL, C_ALWAYS,    P_SIFT,   OP_BDEC);
      P_BLOOP:  w = uw(SQ_JUMP, C_ALWAYS,    P_BTEST,  OP_NONE);
      P_EXINIT: w = uw(SQ_NEXT, C_ALWAYS,    P_LOAD,   OP_EXINIT);
      P_ETEST:  w = uw(SQ_JUMP, C_I_ZERO,    P_EMINIT, OP_NONE);
      P_SWRD:   w = uw(SQ_NEXT, C_ALWAYS,    P_LOAD,   OP_SWAP_RD);
      P_SWW1:   w = uw(SQ_NEXT, C_ALWAYS,    P_LOAD,   OP_SWAP_WR1);
      P_SWW2:   w = uw(SQ_CALL, C_ALWAYS,    P_SIFT,   OP_SWAP_WR2);
      P_ELOOP:  w = uw(SQ_JUMP, C_ALWAYS,    P_ETEST,  OP_NONE);
      P_SIFT:   w = uw(SQ_NEXT, C_ALWAYS,    P_LOAD,   OP_SIFT_ROOT);
      P_SHELD:  w = uw(SQ_NEXT, C_ALWAYS,    P_LOAD,   OP_SIFT_HELD);
      P_SLOOP:  w = uw(SQ_JUMP, C_CHILD_OUT, P_SEND,   OP_SIFT_KIDS);
      P_SPICK:  w = uw(SQ_NEXT, C_ALWAYS,    P_LOAD,   OP_SIFT_PICK);
      P_SMOVE:  w = uw(SQ_JUMP, C_HELD_LT,   P_SLOOP,  OP_SIFT_MOVE);
      P_SEND:   w = uw(SQ_RET,  C_ALWAYS,    P_LOAD,   OP_SIFT_END);
      P_EMINIT: w = uw(SQ_NEXT, C_ALWAYS,    P_LOAD,   OP_EMIT_INIT);
      P_EREAD:  w = uw(SQ_NEXT, C_ALWAYS,    P_LOAD,   OP_EMIT_RD);
      P_EMIT:   w = uw(SQ_JUMP, C_OUT_STALL, P_EMIT,   OP_EMIT);
      P_ENEXT:  w = uw(SQ_JUMP, C_K_LT_N,    P_EREAD,  OP_NONE);
      P_CLEAR:  w = uw(SQ_JUMP, C_ALWAYS,    P_LOAD,   OP_CLEAR);
      default:  w = uw(SQ_JUMP, C_ALWAYS,    P_LOAD,   OP_NONE);
    endcase
    return w;
  endfunction

endpackage

@@ src/hse_if.sv @@
// ----------------------------------------------------------------------------
// hse_in_if / hse_out_if
// Valid/ready channels for input samples and sorted results.
// ----------------------------------------------------------------------------
interface hse_in_if;
  import hse_pkg::*;

  logic                     valid;
  logic                     ready;
  logic signed [DATA_W-1:0] sample_value;
  logic                     end_of_set;

  modport source (output valid, output sample_value, output end_of_set, input ready);
  modport sink   (input valid, input sample_value, input end_of_set, output ready);
endinterface

interface hse_out_if;
  import hse_pkg::*;

  logic                     valid;
  logic                     ready;
  logic signed [DATA_W-1:0] sorted_value;
  logic                     final_flag;
  logic [CMP_W-1:0]         compare_total;
  logic                     overflow_flag;

  modport source (output valid, output sorted_value, output final_flag,
                  output compare_total, output overflow_flag, input ready);
  modport sink   (input valid, input sorted_value, input final_flag,
                  input compare_total, input overflow_flag, output ready);
endinterface

@@ src/hse_store.sv @@
// ----------------------------------------------------------------------------
// hse_store
// Element store: one write port, two registered read ports.
// ----------------------------------------------------------------------------
module hse_store (
  input  logic                       clk,
  input  logic                       we,
  input  logic [hse_pkg::ADDR_W-1:0] waddr,
  input  logic [hse_pkg::DATA_W-1:0] wdata,
  input  logic                       re_a,
  input  logic [hse_pkg::ADDR_W-1:0] raddr_a,
  output logic [hse_pkg::DATA_W-1:0] rdata_a,
  input  logic                       re_b,
  input  logic [hse_pkg::ADDR_W-1:0] raddr_b,
  output logic [hse_pkg::DATA_W-1:0] rdata_b
);
  import hse_pkg::*;

  logic [DATA_W-1:0] mem [STORE_DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    // read data holds while the port is idle
    if (re_a) begin
      rdata_a <= mem[raddr_a];
    end
    if (re_b) begin
      rdata_b <= mem[raddr_b];
    end
  end

endmodule

@@ src/hse_seq.sv @@
// ----------------------------------------------------------------------------
// hse_seq
// Microcode sequencer: step counter, one-level return register, ROM lookup.
// ----------------------------------------------------------------------------
module hse_seq (
  input  logic             clk,
  input  logic             rst,
  input  hse_pkg::status_t status,
  output hse_pkg::ctrl_t   ctrl
);
  import hse_pkg::*;

  pc_t  pc;
  pc_t  pc_next;
  pc_t  ret_pc;
  pc_t  pc_inc;
  logic cond_hit;

  assign ctrl   = ucode(pc);
  assign pc_inc = pc + pc_t'(1);

  always_comb begin
    unique case (ctrl.cond)
      C_ALWAYS:    cond_hit = 1'b1;
      C_WAIT_LOAD: cond_hit = !status.load_done;
      C_I_ZERO:    cond_hit = status.i_zero;
      C_CHILD_OUT: cond_hit = status.child_out;
      C_HELD_LT:   cond_hit = status.held_lt;
      C_OUT_STALL: cond_hit = status.out_stall;
      C_K_LT_N:    cond_hit = status.k_lt_n;
      default:     cond_hit = 1'b0;
    endcase
  end

  always_comb begin
    unique case (ctrl.seq)
      SQ_NEXT: pc_next = pc_inc;
      SQ_JUMP: pc_next = cond_hit ? ctrl.target : pc_inc;
      SQ_CALL: pc_next = ctrl.target;
      SQ_RET:  pc_next = ret_pc;
      default: pc_next = P_LOAD;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pc     <= P_LOAD;
      ret_pc <= P_LOAD;
    end else begin
      pc <= pc_next;
      if (ctrl.seq == SQ_CALL) begin
        ret_pc <= pc_inc;
      end
    end
  end

endmodule

@@ src/heap_sort_engine.sv @@
// ----------------------------------------------------------------------------
// heap_sort_engine
// Collects up to 64 signed samples, heap-sorts them and streams them out.
// ----------------------------------------------------------------------------
// Samples are taken one per cycle until an item with end_of_set; samples past
// 64 are dropped and flagged. The input then stalls while a microcoded
// sequencer heap-sorts the store through its single write port: each sift-down
// step reads both children, picks the larger and moves it into the hole while
// it exceeds the held value, and each extraction swaps the root with the last
// item and sifts again. Each result is then read from the store and loaded
// into the output register, which waits while the sink stalls. After the last
// result the sequencer passes its loop test and clear step, and the input opens
// again. Reset needs no clearing pass.
module heap_sort_engine (
  input logic  clk,
  input logic  rst,
  hse_in_if.sink    samples,
  hse_out_if.source results
);
  import hse_pkg::*;

  ctrl_t   ctrl;
  status_t status;

  logic [CNT_W-1:0]   count;
  logic               dropped;
  logic [CMP_W-1:0]   cmp;
  logic [CNT_W-1:0]   n;
  logic [CNT_W-1:0]   i;
  logic [CNT_W-1:0]   size;
  logic [CNT_W-1:0]   k;
  logic [ADDR_W-1:0]  hole;
  logic [CHILD_W-1:0] child;
  logic [DATA_W-1:0]  held;
  logic [DATA_W-1:0]  big;

  logic               out_valid;
  logic [DATA_W-1:0]  out_value;
  logic               out_final;
  logic [CMP_W-1:0]   out_cmp;
  logic               out_ovf;

  logic               we;
  logic [ADDR_W-1:0]  waddr;
  logic [DATA_W-1:0]  wdata;
  logic               re_a;
  logic [ADDR_W-1:0]  raddr_a;
  logic [DATA_W-1:0]  rdata_a;
  logic               re_b;
  logic [ADDR_W-1:0]  raddr_b;
  logic [DATA_W-1:0]  rdata_b;

  logic               in_fire;
  logic               room;
  logic               has2;
  logic               pick_b;
  logic               held_ge;
  logic               emit_ok;
  logic [CNT_W-1:0]   i_dec;
  logic [CNT_W-1:0]   k_inc;

  hse_seq u_seq (
    .clk    (clk),
    .rst    (rst),
    .status (status),
    .ctrl   (ctrl)
  );

  hse_store u_store (
    .clk     (clk),
    .we      (we),
    .waddr   (waddr),
    .wdata   (wdata),
    .re_a    (re_a),
    .raddr_a (raddr_a),
    .rdata_a (rdata_a),
    .re_b    (re_b),
    .raddr_b (raddr_b),
    .rdata_b (rdata_b)
  );

  assign samples.ready = (ctrl.op == OP_LOAD);
  assign in_fire       = samples.valid && samples.ready;
  assign room          = count < CNT_W'(MAX_ITEMS);
  assign i_dec         = i - CNT_W'(1);
  assign k_inc         = k + CNT_W'(1);
  assign has2          = ((CHILD_W + 1)'(child) + (CHILD_W + 1)'(1)) < (CHILD_W + 1)'(size);
  assign pick_b        = has2 && ($signed(rdata_a) < $signed(rdata_b));
  assign held_ge       = $signed(held) >= $signed(big);
  assign emit_ok       = !out_valid || results.ready;

  assign status.load_done = in_fire && samples.end_of_set;
  assign status.i_zero    = (i == '0);
  assign status.child_out = child >= CHILD_W'(size);
  assign status.held_lt   = !held_ge;
  assign status.out_stall = !emit_ok;
  assign status.k_lt_n    = k < n;

  assign results.valid         = out_valid;
  assign results.sorted_value  = out_value;
  assign results.final_flag    = out_final;
  assign results.compare_total = out_cmp;
  assign results.overflow_flag = out_ovf;

  // store port steering
  always_comb begin
    we      = 1'b0;
    waddr   = hole;
    wdata   = held;
    re_a    = 1'b0;
    raddr_a = hole;
    re_b    = 1'b0;
    raddr_b = i_dec[ADDR_W-1:0];
    unique case (ctrl.op)
      OP_LOAD: begin
        we    = in_fire && room;
        waddr = count[ADDR_W-1:0];
        wdata = samples.sample_value;
      end
      OP_SWAP_RD: begin
        re_a    = 1'b1;
        raddr_a = '0;
        re_b    = 1'b1;
      end
      OP_SWAP_WR1: begin
        we    = 1'b1;
        waddr = i_dec[ADDR_W-1:0];
        wdata = rdata_a;
      end
      OP_SWAP_WR2: begin
        we    = 1'b1;
        waddr = '0;
      end
      OP_SIFT_ROOT: begin
        re_a = 1'b1;
      end
      OP_SIFT_KIDS: begin
        re_a    = 1'b1;
        raddr_a = child[ADDR_W-1:0];
        re_b    = 1'b1;
        raddr_b = child[ADDR_W-1:0] + ADDR_W'(1);
      end
      OP_SIFT_MOVE: begin
        we    = !held_ge;
        wdata = big;
      end
      OP_SIFT_END: begin
        we = 1'b1;
      end
      OP_EMIT_RD: begin
        re_a    = 1'b1;
        raddr_a = k[ADDR_W-1:0];
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count     <= '0;
      dropped   <= 1'b0;
      cmp       <= '0;
      n         <= '0;
      i         <= '0;
      size      <= '0;
      k         <= '0;
      out_valid <= 1'b0;
    end else begin
      if ((ctrl.op == OP_EMIT) && emit_ok) begin
        out_valid <= 1'b1;
      end else if (results.valid && results.ready) begin
        out_valid <= 1'b0;
      end
      unique case (ctrl.op)
        OP_LOAD: begin
          if (in_fire) begin
            if (room) begin
              count <= count + CNT_W'(1);
            end else begin
              dropped <= 1'b1;
            end
          end
        end
        OP_SETUP: begin
          n   <= count;
          i   <= count >> 1;
          cmp <= '0;
        end
        OP_BDEC: begin
          i    <= i_dec;
          hole <= i_dec[ADDR_W-1:0];
          size <= n;
        end
        OP_EXINIT: begin
          i <= n;
        end
        OP_SWAP_WR1: begin
          held <= rdata_b;
        end
        OP_SWAP_WR2: begin
          hole <= '0;
          size <= i_dec;
          i    <= i_dec;
        end
        OP_SIFT_ROOT: begin
          child <= {hole, 1'b1};
        end
        OP_SIFT_HELD: begin
          held <= rdata_a;
        end
        OP_SIFT_PICK: begin
          big <= pick_b ? rdata_b : rdata_a;
          if (pick_b) begin
            child <= child + CHILD_W'(1);
          end
          if (cmp != CMP_MAX) begin
            cmp <= cmp + CMP_W'(1);
          end
        end
        OP_SIFT_MOVE: begin
          if (!held_ge) begin
            hole  <= child[ADDR_W-1:0];
            child <= {child[ADDR_W-1:0], 1'b1};
          end
        end
        OP_EMIT_INIT: begin
          k <= '0;
        end
        OP_EMIT: begin
          if (emit_ok) begin
            out_value <= rdata_a;
            out_final <= (k_inc == n);
            out_cmp   <= cmp;
            out_ovf   <= dropped;
            k         <= k_inc;
          end
        end
        OP_CLEAR: begin
          count   <= '0;
          cmp     <= '0;
          dropped <= 1'b0;
        end
        default: begin
        end
      endcase
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_W'(MAX_ITEMS))
    else $error("sample count past capacity");

  a_last_stops_load: assert property (@(posedge clk) disable iff (rst)
    (in_fire && samples.end_of_set) |=> !samples.ready)
    else $error("input still open after last item");

  a_emit_in_range: assert property (@(posedge clk) disable iff (rst)
    (ctrl.op == OP_EMIT) |-> (k < n))
    else $error("emit index past run length");

  a_sift_order: assert property (@(posedge clk) disable iff (rst)
    (ctrl.op == OP_SIFT_MOVE) |-> ((CHILD_W'(hole) < child) && (child < CHILD_W'(size))))
    else $error("sift child outside heap");

endmodule
